[hdl/sdbl_pkg.sv]
package sdbl_pkg;

    localparam int MAX_ROWS    = 128;
    localparam int MAX_COLS    = 128;
    localparam int ALT_BITS    = 16;
    localparam int LABEL_BITS  = 8;
    localparam int DIM_BITS    = 8;
    localparam int CELL_BITS   = 14;
    localparam int COUNT_BITS  = 15;
    localparam int SINK_BITS   = LABEL_BITS + 1;
    localparam int LABEL_LIMIT = 1 << LABEL_BITS;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_TGT,
        ST_FIND_RD,
        ST_FIND_WT,
        ST_CMP_RD,
        ST_CMP_WT,
        ST_SINK_RD,
        ST_SINK_WT,
        ST_DONE
    } state_t;

endpackage

[hdl/sdbl_ram.sv]
module sdbl_ram #(
    parameter int DW = 8,
    parameter int AW = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/steepest_descent_basin_labeler_core.sv]
// Basin labeler: load items write one altitude and return a status item in the next cycle; a
// read item returns its cell's label through the label store read and the ST_READ state. A
// compute item over n = rows*cols cells clears the sink store, fetches each cell and its four
// neighbors through the altitude store's single read port, then walks the flow chains (with
// path compression) through the target store. No item is accepted during a compute.
module steepest_descent_basin_labeler_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [1:0]                     opcode,
    input  logic [sdbl_pkg::CELL_BITS-1:0] cell_index,
    input  logic [sdbl_pkg::ALT_BITS-1:0]  altitude,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [sdbl_pkg::LABEL_BITS-1:0] label,
    output logic [sdbl_pkg::COUNT_BITS-1:0] basin_count,
    output logic                           overflow,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [sdbl_pkg::DIM_BITS-1:0]  cfg_data
);
    import sdbl_pkg::*;

    state_t state_reg, state_next;
    logic [DIM_BITS-1:0]   rows_reg, cols_reg;
    logic [CELL_BITS-1:0]  i_reg, i_next;
    logic [DIM_BITS-1:0]   r_reg, r_next, c_reg, c_next;
    logic [2:0]            step_reg, step_next;
    logic [ALT_BITS-1:0]   h_reg, h_next, best_alt_reg, best_alt_next;
    logic [CELL_BITS-1:0]  best_reg, best_next;
    logic                  found_reg, found_next;
    logic [CELL_BITS-1:0]  root_reg, root_next, y_reg, y_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LABEL_BITS-1:0] out_label_reg, out_label_next;
    logic [COUNT_BITS-1:0] out_cnt_reg, out_cnt_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic [DIM_BITS-1:0]   rows_eff, cols_eff;
    logic [COUNT_BITS-1:0] n_cells;
    logic                  last_cell, accept, idx_ok;

    logic                  alt_we, tgt_we, sink_we, lbl_we;
    logic [CELL_BITS-1:0]  alt_raddr, tgt_waddr, tgt_raddr, sink_waddr, sink_raddr, lbl_raddr;
    logic [CELL_BITS-1:0]  tgt_wdata, tgt_q;
    logic [ALT_BITS-1:0]   alt_q;
    logic [SINK_BITS-1:0]  sink_wdata, sink_q;
    logic [LABEL_BITS-1:0] lbl_wdata, lbl_q, lab;

    logic [CELL_BITS-1:0]  slot_addr [5];
    logic                  slot_ok [5];
    logic [2:0]            pslot;

    always_comb
    begin
        if (rows_reg == '0)
            rows_eff = 8'd1;
        else if (rows_reg > DIM_BITS'(MAX_ROWS))
            rows_eff = DIM_BITS'(MAX_ROWS);
        else
            rows_eff = rows_reg;
        if (cols_reg == '0)
            cols_eff = 8'd1;
        else if (cols_reg > DIM_BITS'(MAX_COLS))
            cols_eff = DIM_BITS'(MAX_COLS);
        else
            cols_eff = cols_reg;
    end

    assign n_cells   = COUNT_BITS'({7'b0, rows_eff} * {7'b0, cols_eff});
    assign last_cell = ({1'b0, i_reg} == n_cells - 15'd1);
    assign idx_ok    = ({1'b0, cell_index} < n_cells);
    assign item_stall = !((state_reg == ST_IDLE) && !(out_valid_reg && result_stall));
    assign accept    = item_valid && !item_stall;
    assign cfg_ready = 1'b1;

    // center, north, west, east, south
    always_comb
    begin
        slot_addr[0] = i_reg;
        slot_addr[1] = i_reg - {6'b0, cols_eff};
        slot_addr[2] = i_reg - 14'd1;
        slot_addr[3] = i_reg + 14'd1;
        slot_addr[4] = i_reg + {6'b0, cols_eff};
        slot_ok[0]   = 1'b1;
        slot_ok[1]   = (r_reg != '0);
        slot_ok[2]   = (c_reg != '0);
        slot_ok[3]   = ((c_reg + 8'd1) < cols_eff);
        slot_ok[4]   = ((r_reg + 8'd1) < rows_eff);
    end

    assign pslot = step_reg - 3'd1;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        step_next      = step_reg;
        h_next         = h_reg;
        best_next      = best_reg;
        best_alt_next  = best_alt_reg;
        found_next     = found_reg;
        root_next      = root_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_label_next = out_label_reg;
        out_cnt_next   = out_cnt_reg;
        out_ovf_next   = out_ovf_reg;
        alt_we     = 1'b0;
        alt_raddr  = i_reg;
        tgt_we     = 1'b0;
        tgt_waddr  = i_reg;
        tgt_wdata  = i_reg;
        tgt_raddr  = root_reg;
        sink_we    = 1'b0;
        sink_waddr = i_reg;
        sink_wdata = '0;
        sink_raddr = root_reg;
        lbl_we     = 1'b0;
        lbl_wdata  = '0;
        lbl_raddr  = cell_index;
        lab        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_COMPUTE:
                        begin
                            i_next     = '0;
                            cnt_next   = '0;
                            ovf_next   = 1'b0;
                            state_next = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            rd_ok_next = idx_ok;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            alt_we         = (opcode == OP_LOAD) && idx_ok;
                            out_valid_next = 1'b1;
                            out_label_next = '0;
                            out_cnt_next   = cnt_reg;
                            out_ovf_next   = ovf_reg;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_label_next = rd_ok_reg ? lbl_q : '0;
                out_cnt_next   = cnt_reg;
                out_ovf_next   = ovf_reg;
                state_next     = ST_IDLE;
            end
            ST_CLEAR:
            begin
                sink_we = 1'b1;
                if (last_cell)
                begin
                    i_next     = '0;
                    r_next     = '0;
                    c_next     = '0;
                    step_next  = '0;
                    state_next = ST_TGT;
                end
                else
                begin
                    i_next = i_reg + 14'd1;
                end
            end
            ST_TGT:
            begin
                if (step_reg < 3'd5)
                begin
                    alt_raddr = slot_ok[step_reg] ? slot_addr[step_reg] : i_reg;
                end
                if (step_reg != '0)
                begin
                    if (pslot == '0)
                    begin
                        h_next     = alt_q;
                        found_next = 1'b0;
                    end
                    else if (slot_ok[pslot] && (alt_q < h_reg)
                             && (!found_reg || (alt_q < best_alt_reg)))
                    begin
                        best_next     = slot_addr[pslot];
                        best_alt_next = alt_q;
                        found_next    = 1'b1;
                    end
                end
                if (step_reg == 3'd5)
                begin
                    tgt_we    = 1'b1;
                    tgt_wdata = found_next ? best_next : i_reg;
                    step_next = '0;
                    if (last_cell)
                    begin
                        i_next     = '0;
                        root_next  = '0;
                        state_next = ST_FIND_RD;
                    end
                    else
                    begin
                        i_next = i_reg + 14'd1;
                        if ((c_reg + 8'd1) == cols_eff)
                        begin
                            c_next = '0;
                            r_next = r_reg + 8'd1;
                        end
                        else
                        begin
                            c_next = c_reg + 8'd1;
                        end
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_FIND_RD:
            begin
                state_next = ST_FIND_WT;
            end
            ST_FIND_WT:
            begin
                if (tgt_q == root_reg)
                begin
                    y_next     = i_reg;
                    state_next = ST_CMP_RD;
                end
                else
                begin
                    root_next = tgt_q;
                    tgt_raddr = tgt_q;
                end
            end
            ST_CMP_RD:
            begin
                tgt_raddr  = y_reg;
                state_next = ST_CMP_WT;
            end
            ST_CMP_WT:
            begin
                if ((tgt_q == root_reg) || (y_reg == root_reg))
                begin
                    state_next = ST_SINK_RD;
                end
                else
                begin
                    // chains strictly descend, so the write and the next read never collide
                    tgt_we    = 1'b1;
                    tgt_waddr = y_reg;
                    tgt_wdata = root_reg;
                    y_next    = tgt_q;
                    tgt_raddr = tgt_q;
                end
            end
            ST_SINK_RD:
            begin
                state_next = ST_SINK_WT;
            end
            ST_SINK_WT:
            begin
                if (!sink_q[LABEL_BITS])
                begin
                    if (cnt_reg >= COUNT_BITS'(LABEL_LIMIT))
                    begin
                        lab      = LABEL_BITS'(LABEL_LIMIT - 1);
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        lab = cnt_reg[LABEL_BITS-1:0];
                    end
                    sink_we    = 1'b1;
                    sink_waddr = root_reg;
                    sink_wdata = {1'b1, lab};
                    cnt_next   = cnt_reg + 15'd1;
                end
                else
                begin
                    lab = sink_q[LABEL_BITS-1:0];
                end
                lbl_we    = 1'b1;
                lbl_wdata = lab;
                if (last_cell)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    i_next     = i_reg + 14'd1;
                    root_next  = i_reg + 14'd1;
                    state_next = ST_FIND_RD;
                end
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                out_label_next = '0;
                out_cnt_next   = cnt_reg;
                out_ovf_next   = ovf_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_reg      <= 8'd1;
            cols_reg      <= 8'd1;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ROWS: rows_reg <= cfg_data;
                    REG_COLS: cols_reg <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        step_reg      <= step_next;
        h_reg         <= h_next;
        best_reg      <= best_next;
        best_alt_reg  <= best_alt_next;
        found_reg     <= found_next;
        root_reg      <= root_next;
        y_reg         <= y_next;
        rd_ok_reg     <= rd_ok_next;
        out_label_reg <= out_label_next;
        out_cnt_reg   <= out_cnt_next;
        out_ovf_reg   <= out_ovf_next;
    end

    sdbl_ram #(.DW(ALT_BITS), .AW(CELL_BITS)) u_alt (
        .clk(clk), .we(alt_we), .waddr(cell_index), .wdata(altitude),
        .raddr(alt_raddr), .rdata(alt_q)
    );

    sdbl_ram #(.DW(CELL_BITS), .AW(CELL_BITS)) u_tgt (
        .clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
        .raddr(tgt_raddr), .rdata(tgt_q)
    );

    sdbl_ram #(.DW(SINK_BITS), .AW(CELL_BITS)) u_sink (
        .clk(clk), .we(sink_we), .waddr(sink_waddr), .wdata(sink_wdata),
        .raddr(sink_raddr), .rdata(sink_q)
    );

    sdbl_ram #(.DW(LABEL_BITS), .AW(CELL_BITS)) u_lbl (
        .clk(clk), .we(lbl_we), .waddr(i_reg), .wdata(lbl_wdata),
        .raddr(lbl_raddr), .rdata(lbl_q)
    );

    assign result_valid = out_valid_reg;
    assign label        = out_label_reg;
    assign basin_count  = out_cnt_reg;
    assign overflow     = out_ovf_reg;
endmodule

[hdl/sdbl_checker.sv]
module sdbl_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            item_stall,
    input logic                            result_valid,
    input logic                            result_stall,
    input logic [sdbl_pkg::COUNT_BITS-1:0] basin_count,
    input logic                            overflow
);
    import sdbl_pkg::*;

    // a result waiting on the far side holds off new items
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |-> item_stall)
        else $error("item taken while result is stuck");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result dropped while stalled");

    // labels saturate only after the label space is used up
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflow) |-> (basin_count > COUNT_BITS'(LABEL_LIMIT)))
        else $error("overflow with too few basins");
endmodule

bind steepest_descent_basin_labeler_core sdbl_checker u_sdbl_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import sdbl_pkg::*;

    localparam logic [1:0] OP_NOP     = 2'd3;
    localparam logic [1:0] REG_SPARE  = 2'd2;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int SETTLE = 4;

    typedef enum logic [1:0] {K_ITEM, K_CFG, K_HOLD} entry_kind_t;

    typedef struct {
        entry_kind_t           kind;
        logic [1:0]            op;
        logic [CELL_BITS-1:0]  idx;
        logic [ALT_BITS-1:0]   alt;
        logic [1:0]            reg_idx;
        logic [DIM_BITS-1:0]   reg_val;
    } entry_t;

    typedef struct {
        logic [LABEL_BITS-1:0] label;
        logic [COUNT_BITS-1:0] count;
        logic                  ovf;
    } status_t;

    logic clk, rst_n;
    logic item_valid, item_stall;
    logic [1:0] opcode;
    logic [CELL_BITS-1:0] cell_index;
    logic [ALT_BITS-1:0] altitude;
    logic result_valid, result_stall;
    logic [LABEL_BITS-1:0] label;
    logic [COUNT_BITS-1:0] basin_count;
    logic overflow;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [DIM_BITS-1:0] cfg_data;

    steepest_descent_basin_labeler_core dut (.*);

    entry_t  pending_items[$];
    status_t expected_status[$];
    int      errors = 0;

    // predictor state
    logic [ALT_BITS-1:0]   alt_mem[DEPTH];
    logic [LABEL_BITS-1:0] basin_mem[DEPTH];
    logic [DIM_BITS-1:0]   rows_reg = 1, cols_reg = 1;
    logic [COUNT_BITS-1:0] basins_seen = 0;
    logic                  ovf_seen = 0;

    // generator's view, so reads stay inside the contract
    bit gen_labeled[DEPTH];
    logic [DIM_BITS-1:0] gen_rows = 1, gen_cols = 1;
    int item_total = 0;

    function automatic void enqueue_entry(entry_t e);
        pending_items = {pending_items, e};
    endfunction

    function automatic void enqueue_status(status_t s);
        expected_status = {expected_status, s};
    endfunction

    function automatic int eff_dim(logic [DIM_BITS-1:0] v, int lim);
        if (v == 0) return 1;
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic void label_basins();
        int rows, cols, n, r, c, best, h, root;
        int target[];
        int sink_lab[];
        rows = eff_dim(rows_reg, MAX_ROWS);
        cols = eff_dim(cols_reg, MAX_COLS);
        n = rows * cols;
        target = new[n];
        sink_lab = new[n];
        for (int i = 0; i < n; i++) begin
            r = i / cols;
            c = i % cols;
            h = int'(alt_mem[i]);
            best = i;
            // strict compare keeps the earlier neighbor on a tie
            if (r > 0 && int'(alt_mem[i-cols]) < h) begin
                best = i - cols; h = int'(alt_mem[best]);
            end
            if (c > 0 && int'(alt_mem[i-1]) < h) begin
                best = i - 1; h = int'(alt_mem[best]);
            end
            if (c + 1 < cols && int'(alt_mem[i+1]) < h) begin
                best = i + 1; h = int'(alt_mem[best]);
            end
            if (r + 1 < rows && int'(alt_mem[i+cols]) < h) begin
                best = i + cols; h = int'(alt_mem[best]);
            end
            target[i] = best;
            sink_lab[i] = -1;
        end
        basins_seen = 0;
        ovf_seen = 0;
        for (int i = 0; i < n; i++) begin
            root = i;
            while (target[root] != root) root = target[root];
            if (sink_lab[root] < 0) begin
                if (int'(basins_seen) >= LABEL_LIMIT) ovf_seen = 1;
                sink_lab[root] = (int'(basins_seen) >= LABEL_LIMIT) ? LABEL_LIMIT - 1
                                                                    : int'(basins_seen);
                basins_seen++;
            end
            basin_mem[i] = LABEL_BITS'(sink_lab[root]);
        end
    endfunction

    function automatic status_t basin_step(entry_t e);
        status_t s;
        int n;
        n = eff_dim(rows_reg, MAX_ROWS) * eff_dim(cols_reg, MAX_COLS);
        s.label = 0;
        case (e.op)
            OP_LOAD:    if (int'(e.idx) < n) alt_mem[e.idx] = e.alt;
            OP_COMPUTE: label_basins();
            OP_READ:    if (int'(e.idx) < n) s.label = basin_mem[e.idx];
            default: ;
        endcase
        s.count = basins_seen;
        s.ovf = ovf_seen;
        return s;
    endfunction

    // ---------------- stimulus ----------------
    function automatic void push_item(logic [1:0] op, int idx, logic [ALT_BITS-1:0] alt);
        entry_t e;
        int n;
        n = eff_dim(gen_rows, MAX_ROWS) * eff_dim(gen_cols, MAX_COLS);
        e.kind = K_ITEM;
        e.op = op;
        e.idx = CELL_BITS'(idx);
        e.alt = alt;
        e.reg_idx = 0;
        e.reg_val = 0;
        if (op == OP_COMPUTE)
            for (int i = 0; i < n; i++) gen_labeled[i] = 1;
        enqueue_entry(e);
        item_total++;
    endfunction

    function automatic void push_cfg(logic [1:0] ri, logic [DIM_BITS-1:0] v);
        entry_t e;
        e.kind = K_CFG;
        e.op = 0;
        e.idx = 0;
        e.alt = 0;
        e.reg_idx = ri;
        e.reg_val = v;
        if (ri == REG_ROWS) gen_rows = v;
        if (ri == REG_COLS) gen_cols = v;
        enqueue_entry(e);
    endfunction

    function automatic void push_hold();
        entry_t e;
        e = '{K_HOLD, 0, 0, 0, 0, 0};
        enqueue_entry(e);
    endfunction

    function automatic logic [ALT_BITS-1:0] rand_alt(int style);
        case (style)
            0: return ALT_BITS'($urandom_range(0, 3));             // plateaus and ties
            1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return ALT_BITS'($urandom());
        endcase
    endfunction

    function automatic void load_grid(int style);
        int n;
        n = eff_dim(gen_rows, MAX_ROWS) * eff_dim(gen_cols, MAX_COLS);
        for (int i = 0; i < n; i++) push_item(OP_LOAD, i, rand_alt(style));
    endfunction

    function automatic void random_ops(int count);
        int n, k, idx;
        n = eff_dim(gen_rows, MAX_ROWS) * eff_dim(gen_cols, MAX_COLS);
        for (int j = 0; j < count; j++) begin
            k = $urandom_range(0, 99);
            if (k < 35)
                push_item(OP_LOAD, $urandom_range(0, n - 1), rand_alt($urandom_range(0, 2)));
            else if (k < 40)
                push_item(OP_LOAD, $urandom_range(0, DEPTH - 1), ALT_BITS'($urandom()));
            else if (k < 80) begin
                idx = $urandom_range(0, n - 1);
                if (!gen_labeled[idx]) idx = (n < DEPTH) ? $urandom_range(n, DEPTH - 1) : 0;
                push_item(OP_READ, idx, ALT_BITS'($urandom()));
            end else if (k < 85)
                push_item(OP_READ, $urandom_range(0, DEPTH - 1) | (n < DEPTH ? 0 : 0), 0);
            else if (k < 93)
                push_item(OP_COMPUTE, $urandom_range(0, DEPTH - 1), ALT_BITS'($urandom()));
            else
                push_item(OP_NOP, $urandom_range(0, DEPTH - 1), ALT_BITS'($urandom()));
        end
    endfunction

    function automatic void build_stimulus();
        int r, c;
        // directed: reset grid of one cell
        push_item(OP_LOAD, 0, 16'hFFFF);
        push_item(OP_COMPUTE, 0, 0);
        push_item(OP_READ, 0, 0);
        push_item(OP_READ, DEPTH - 1, 16'hFFFF);
        push_item(OP_LOAD, DEPTH - 1, 16'hFFFF);
        push_item(OP_NOP, 16'h2AAA, 16'h5555);
        // 3x3: center drains, all four neighbors tie -> north wins
        push_cfg(REG_ROWS, 3);
        push_cfg(REG_COLS, 3);
        push_cfg(REG_SPARE, 8'hFF);
        push_cfg(REG_UNUSED, 8'h55);
        for (int i = 0; i < 9; i++)
            push_item(OP_LOAD, i, (i == 4) ? 16'd9 : (i % 2 == 1) ? 16'd2 : 16'd7);
        push_item(OP_COMPUTE, 0, 0);
        for (int i = 0; i < 9; i++) push_item(OP_READ, i, 0);
        push_hold();
        // register extremes: zero acts as one, above the maximum clamps
        push_cfg(REG_ROWS, 0);
        push_cfg(REG_COLS, 8'hFF);
        load_grid(2);
        push_item(OP_COMPUTE, 0, 0);
        random_ops(30);
        push_cfg(REG_ROWS, 128);
        push_cfg(REG_COLS, 1);
        load_grid(0);
        push_item(OP_COMPUTE, 0, 0);
        random_ops(30);
        // checkerboard: 512 sinks, labels saturate
        push_cfg(REG_ROWS, 32);
        push_cfg(REG_COLS, 32);
        for (int i = 0; i < 1024; i++)
            push_item(OP_LOAD, i, (((i / 32) + (i % 32)) % 2 == 0) ? 16'd1 : 16'd900);
        push_item(OP_COMPUTE, 0, 0);
        random_ops(20);
        push_hold();
        random_ops(20);
        while (item_total < 1700) begin
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 8);
            c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 8);
            if (eff_dim(DIM_BITS'(r), MAX_ROWS) * eff_dim(DIM_BITS'(c), MAX_COLS) > 200)
                c = $urandom_range(1, 2);
            push_cfg(REG_ROWS, DIM_BITS'(r));
            push_cfg(REG_COLS, DIM_BITS'(c));
            load_grid($urandom_range(0, 2));
            push_item(OP_COMPUTE, 0, 0);
            random_ops($urandom_range(10, 50));
        end
    endfunction

    function automatic int draw_wait(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 9);
    endfunction

    // ---------------- clock and reset ----------------
    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // ---------------- driver ----------------
    bit item_taken = 0, cfg_taken = 0, holding = 0, cfg_holding = 0;
    int gap = 0, send_calm = 0, quiet = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (item_valid && !item_stall) begin
                enqueue_status(basin_step('{K_ITEM, opcode, cell_index,
                                            altitude, 0, 0}));
                item_taken = 1;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ROWS) rows_reg = cfg_data;
                if (cfg_index == REG_COLS) cols_reg = cfg_data;
                cfg_taken = 1;
            end
            quiet = (expected_status.size() == 0) ? quiet + 1 : 0;
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (item_taken) begin
                item_taken = 0;
                holding = 0;
                gap = draw_wait(send_calm);
            end
            if (cfg_taken) begin
                cfg_taken = 0;
                cfg_holding = 0;
            end
            if (!holding && !cfg_holding) begin
                if (gap > 0)
                    gap--;
                else if (pending_items.size() > 0) begin
                    case (pending_items[0].kind)
                        K_ITEM: begin
                            opcode <= pending_items[0].op;
                            cell_index <= pending_items[0].idx;
                            altitude <= pending_items[0].alt;
                            holding = 1;
                            void'(pending_items.pop_front());
                        end
                        K_CFG:
                            if (expected_status.size() == 0 && quiet >= SETTLE) begin
                                cfg_index <= pending_items[0].reg_idx;
                                cfg_data <= pending_items[0].reg_val;
                                cfg_holding = 1;
                                void'(pending_items.pop_front());
                            end
                        default:
                            if (expected_status.size() == 0)
                                void'(pending_items.pop_front());
                    endcase
                end
            end
            item_valid <= holding;
            cfg_valid <= cfg_holding;
        end
    end

    // ---------------- monitor ----------------
    bit result_taken = 0;
    int stall_left = 0, recv_calm = 0;

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk) begin
        status_t want;
        if (rst_n && result_valid && !result_stall) begin
            result_taken = 1;
            if (expected_status.size() == 0)
                report("unexpected item", 1, 0);
            else begin
                want = expected_status.pop_front();
                if (label !== want.label) report("label", label, want.label);
                if (basin_count !== want.count) report("basin_count", basin_count, want.count);
                if (overflow !== want.ovf) report("overflow", overflow, want.ovf);
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (result_taken) begin
                result_taken = 0;
                stall_left = draw_wait(recv_calm);
            end
            if (stall_left > 0) begin
                stall_left--;
                result_stall <= 1;
            end else
                result_stall <= 0;
        end
    end

    // ---------------- main ----------------
    initial begin
        rst_n = 0;
        item_valid = 0;
        opcode = OP_LOAD;
        cell_index = 0;
        altitude = 0;
        result_stall = 0;
        cfg_valid = 0;
        cfg_index = REG_ROWS;
        cfg_data = 1;
        build_stimulus();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        wait (pending_items.size() == 0 && !holding && !cfg_holding);
        wait (expected_status.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_status.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
